// ----- hw/rtl/thermal_video_packet_deframer_unit_defines.svh -----
// ----------------------------------------------------------------------------
// thermal video packet deframer: assertion macros
// shared concurrent assertion forms, sampled on the rising clock edge and
// disabled while the synchronous active-low reset is asserted
// ----------------------------------------------------------------------------
`ifndef THERMAL_VIDEO_PACKET_DEFRAMER_UNIT_DEFINES_SVH
`define THERMAL_VIDEO_PACKET_DEFRAMER_UNIT_DEFINES_SVH

// same-cycle implication
`define TVPD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tvpd assertion failed");

// next-cycle implication
`define TVPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tvpd assertion failed");

`endif

// ----- hw/rtl/tvpd_pkg.sv -----
// ----------------------------------------------------------------------------
// tvpd_pkg
// types, widths and constants of the thermal video packet deframer
// ----------------------------------------------------------------------------
package tvpd_pkg;

    localparam int unsigned PACKET_BYTES_DEF      = 164;
    localparam int unsigned PIXELS_PER_PACKET_DEF = 80;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned PKT_NUM_W = 6;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned EVT_W     = 2;
    localparam int unsigned INDEX_W   = 13;
    localparam int unsigned PIXEL_W   = 14;

    localparam logic [3:0]        DISCARD_NIBBLE = 4'hF;
    localparam logic [BYTE_W-1:0] PKT_NUM_NONE   = 8'hFF;
    localparam logic [BYTE_W-1:0] POS_HEADER     = 8'd0;
    localparam logic [BYTE_W-1:0] POS_PKT_NUM    = 8'd1;
    localparam int unsigned       POS_PIX_FIRST  = 4;

    localparam logic [COUNT_W-1:0]   SYNC_LIMIT_RST  = 16'd1000;
    localparam logic [COUNT_W-1:0]   RESET_LIMIT_RST = 16'd20000;
    localparam logic [PKT_NUM_W-1:0] PPF_RST         = 6'd60;

    typedef enum logic [1:0] {
        MODE_HEADER = 2'd0,
        MODE_SKIP   = 2'd1,
        MODE_PIXELS = 2'd2
    } t_mode;

    typedef enum logic [EVT_W-1:0] {
        EVT_PIXEL = 2'd0,
        EVT_SYNC  = 2'd1,
        EVT_RESET = 2'd2
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_LIMIT  = 2'd0,
        CFG_RESET_LIMIT = 2'd1,
        CFG_PPF         = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_event               code;
        logic [INDEX_W-1:0]   index;
        logic [PIXEL_W-1:0]   value;
        logic                 done;
    } t_result;

endpackage

// ----- hw/rtl/tvpd_in_if.sv -----
// ----------------------------------------------------------------------------
// tvpd_in_if
// received byte channel: valid/ready with byte and packet start mark
// ----------------------------------------------------------------------------
interface tvpd_in_if import tvpd_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              packet_start;

    modport source (output valid, output rx_byte, output packet_start, input ready);
    modport sink   (input valid, input rx_byte, input packet_start, output ready);

endinterface

// ----- hw/rtl/tvpd_out_if.sv -----
// ----------------------------------------------------------------------------
// tvpd_out_if
// result channel: valid/ready with event code, pixel index, value and frame end
// ----------------------------------------------------------------------------
interface tvpd_out_if import tvpd_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [EVT_W-1:0]   event_code;
    logic [INDEX_W-1:0] pixel_index;
    logic [PIXEL_W-1:0] pixel_value;
    logic               frame_done;

    modport source (output valid, output event_code, output pixel_index,
                    output pixel_value, output frame_done, input ready);
    modport sink   (input valid, input event_code, input pixel_index,
                    input pixel_value, input frame_done, output ready);

endinterface

// ----- hw/rtl/thermal_video_packet_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// thermal_video_packet_deframer_unit
// each result is registered in the output register, or in one skid register
// while the output holds a waiting result, so bytes keep flowing; throughput:
// one byte per cycle while the skid is empty, set by single-pass state update
// reset: synchronous active low, clears position, packet state, counter and
// output flags, and loads the register defaults
// ----------------------------------------------------------------------------
`include "thermal_video_packet_deframer_unit_defines.svh"

module thermal_video_packet_deframer_unit
    import tvpd_pkg::*;
#(
    parameter int unsigned PACKET_BYTES      = PACKET_BYTES_DEF,
    parameter int unsigned PIXELS_PER_PACKET = PIXELS_PER_PACKET_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    tvpd_in_if.sink              i_in,
    tvpd_out_if.source           o_out
);

    localparam logic [BYTE_W:0]   PKT_LEN   = (BYTE_W+1)'(PACKET_BYTES);
    localparam logic [BYTE_W:0]   PIX_FIRST = (BYTE_W+1)'(POS_PIX_FIRST);
    localparam logic [BYTE_W:0]   PIX_END   = (BYTE_W+1)'(POS_PIX_FIRST + 2 * PIXELS_PER_PACKET);
    localparam logic [BYTE_W-2:0] PIX_LAST  = (BYTE_W-1)'(PIXELS_PER_PACKET - 1);
    localparam logic [INDEX_W-1:0] PPP_MUL  = INDEX_W'(PIXELS_PER_PACKET);

    // configuration
    logic [COUNT_W-1:0]   r_sync_limit;
    logic [COUNT_W-1:0]   r_reset_limit;
    logic [PKT_NUM_W-1:0] r_ppf;

    // deframer state
    logic [BYTE_W-1:0]    r_byte_pos,  n_byte_pos;
    logic [PKT_NUM_W-1:0] r_expected,  n_expected;
    logic [COUNT_W-1:0]   r_count,     n_count;
    t_mode                r_mode,      n_mode;
    logic [BYTE_W-1:0]    r_hold,      n_hold;

    // output stage
    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    logic               w_accept;
    logic               w_out_fire;
    logic [BYTE_W-1:0]  w_pos;
    logic [BYTE_W:0]    w_pos_inc;
    logic [BYTE_W-1:0]  w_off;
    logic [BYTE_W-2:0]  w_idx;
    logic               w_in_window;
    logic               w_last_pix;
    logic               w_last_pkt;
    logic [COUNT_W-1:0] w_count_inc;
    logic [INDEX_W-1:0] w_base;
    logic               w_res_valid;
    t_result            w_res;

    assign i_in.ready = !r_skid_valid;
    assign w_accept   = i_in.valid && !r_skid_valid;
    assign w_out_fire = r_out_valid && o_out.ready;

    assign w_pos       = i_in.packet_start ? POS_HEADER : r_byte_pos;
    assign w_pos_inc   = {1'b0, w_pos} + (BYTE_W+1)'(1);
    assign w_off       = w_pos - BYTE_W'(POS_PIX_FIRST);
    assign w_idx       = w_off[BYTE_W-1:1];
    assign w_in_window = ({1'b0, w_pos} >= PIX_FIRST) && ({1'b0, w_pos} < PIX_END);
    assign w_last_pix  = (w_idx == PIX_LAST);
    assign w_last_pkt  = ({1'b0, r_expected} + (PKT_NUM_W+1)'(1)) == {1'b0, r_ppf};
    assign w_count_inc = (r_count != '1) ? r_count + COUNT_W'(1) : r_count;
    assign w_base      = INDEX_W'(r_expected) * PPP_MUL;

    always_comb begin
        n_byte_pos  = r_byte_pos;
        n_expected  = r_expected;
        n_count     = r_count;
        n_mode      = r_mode;
        n_hold      = r_hold;
        w_res_valid = 1'b0;
        w_res       = '0;
        if (w_accept) begin
            n_byte_pos = (w_pos_inc >= PKT_LEN) ? '0 : w_pos_inc[BYTE_W-1:0];
            if (w_pos == POS_HEADER) begin
                if (i_in.rx_byte[3:0] == DISCARD_NIBBLE) begin
                    n_count = w_count_inc;
                    n_mode  = MODE_SKIP;
                    if (w_count_inc > r_reset_limit) begin
                        w_res_valid = 1'b1;
                        w_res.code  = EVT_RESET;
                        n_expected  = '0;
                        n_count     = '0;
                    end
                end else begin
                    n_mode = MODE_HEADER;
                end
            end else if (w_pos == POS_PKT_NUM) begin
                if (r_mode == MODE_HEADER) begin
                    if (i_in.rx_byte >= BYTE_W'(r_ppf) && i_in.rx_byte != PKT_NUM_NONE) begin
                        n_count    = w_count_inc;
                        n_expected = '0;
                        n_mode     = MODE_SKIP;
                        if (w_count_inc > r_sync_limit) begin
                            w_res_valid = 1'b1;
                            w_res.code  = EVT_SYNC;
                        end
                    end else if (i_in.rx_byte == BYTE_W'(r_expected)) begin
                        n_mode = MODE_PIXELS;
                    end else begin
                        n_mode = MODE_SKIP;
                    end
                end
            end else if (r_mode == MODE_PIXELS && w_in_window) begin
                if (!w_off[0]) begin
                    n_hold = i_in.rx_byte;
                end else begin
                    w_res_valid = 1'b1;
                    w_res.code  = EVT_PIXEL;
                    w_res.index = w_base + INDEX_W'(w_idx);
                    w_res.value = {r_hold, i_in.rx_byte[BYTE_W-1:2]};
                    w_res.done  = w_last_pix && w_last_pkt;
                    if (w_last_pix) begin
                        n_mode = MODE_SKIP;
                        if (w_last_pkt) begin
                            n_expected = '0;
                            n_count    = '0;
                        end else begin
                            n_expected = r_expected + PKT_NUM_W'(1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_limit  <= SYNC_LIMIT_RST;
            r_reset_limit <= RESET_LIMIT_RST;
            r_ppf         <= PPF_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SYNC_LIMIT:  r_sync_limit  <= i_cfg_wdata;
                CFG_RESET_LIMIT: r_reset_limit <= i_cfg_wdata;
                CFG_PPF:         r_ppf         <= i_cfg_wdata[PKT_NUM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos <= '0;
            r_expected <= '0;
            r_count    <= '0;
            r_mode     <= MODE_HEADER;
            r_hold     <= '0;
        end else begin
            r_byte_pos <= n_byte_pos;
            r_expected <= n_expected;
            r_count    <= n_count;
            r_mode     <= n_mode;
            r_hold     <= n_hold;
        end
    end

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_fire) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (w_res_valid) begin
            if (!r_out_valid || w_out_fire) begin
                r_out       <= w_res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= w_res;
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.event_code  = r_out.code;
    assign o_out.pixel_index = r_out.index;
    assign o_out.pixel_value = r_out.value;
    assign o_out.frame_done  = r_out.done;

    `TVPD_ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `TVPD_ASSERT_IMPL(a_pos_in_packet, i_clk, i_rst_n, 1'b1, ({1'b0, r_byte_pos} < PKT_LEN))
    `TVPD_ASSERT_IMPL(a_event_no_payload, i_clk, i_rst_n,
        r_out_valid && r_out.code != EVT_PIXEL,
        r_out.index == '0 && r_out.value == '0 && !r_out.done)
    `TVPD_ASSERT_NEXT(a_reset_clears_count, i_clk, i_rst_n,
        w_res_valid && w_res.code == EVT_RESET, r_count == '0 && r_expected == '0)

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: thermal video packet deframer testbench
// drives byte streams of video packets, discard packets, out-of-range and
// skipped packet numbers and random noise through the byte channel, checks
// every pixel, sync and reset request against a cycle-free behavioral model,
// across several register settings and idling patterns with backpressure
// ----------------------------------------------------------------------------
module tb_top
    import tvpd_pkg::*;
();

    localparam int unsigned STALL_CYCLES  = 400;
    localparam int unsigned SETTLE_CYCLES = 8;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              start;
    } t_rx_word;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_wdata;

    tvpd_in_if  byte_ch ();
    tvpd_out_if pix_ch ();

    thermal_video_packet_deframer_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (byte_ch),
        .o_out       (pix_ch)
    );

    t_rx_word byte_backlog[$];
    t_result  due_events[$];

    // deframer model state and register copies
    logic [BYTE_W-1:0]    m_pos;
    logic [PKT_NUM_W-1:0] m_exp_pkt;
    logic [COUNT_W-1:0]   m_disc;
    t_mode                m_mode;
    logic [BYTE_W-1:0]    m_hold;
    logic [COUNT_W-1:0]   lim_sync;
    logic [COUNT_W-1:0]   lim_reset;
    logic [PKT_NUM_W-1:0] pkts_per_frame;

    // stimulus-side tracking of the awaited packet number
    int g_exp;
    int g_disc;
    bit g_aligned;

    int send_idle_pct;
    int recv_stall_pct;
    logic hold_go;
    int unsigned hold_left;

    int words_in;
    int mismatch_count;
    int pixel_count;
    int frame_count;
    int sync_count;
    int reset_count;

    always #5 i_clk = ~i_clk;

    function automatic void bump_discards();
        if (m_disc != 16'hFFFF) begin
            m_disc = m_disc + 16'd1;
        end
    endfunction

    function automatic void push_request(input t_event code);
        t_result r;
        r.code  = code;
        r.index = '0;
        r.value = '0;
        r.done  = 1'b0;
        due_events.push_back(r);
    endfunction

    function automatic void deframe_word(input logic [BYTE_W-1:0] b, input logic start);
        int      pos;
        int      off;
        int      pix;
        bit      last_pix;
        bit      frame_end;
        t_result r;
        pos   = start ? 0 : int'(m_pos);
        m_pos = (pos + 1 >= int'(PACKET_BYTES_DEF)) ? '0 : BYTE_W'(pos + 1);
        if (pos == int'(POS_HEADER)) begin
            if (b[3:0] == DISCARD_NIBBLE) begin
                bump_discards();
                m_mode = MODE_SKIP;
                if (m_disc > lim_reset) begin
                    push_request(EVT_RESET);
                    m_exp_pkt = '0;
                    m_disc    = '0;
                end
            end else begin
                m_mode = MODE_HEADER;
            end
        end else if (pos == int'(POS_PKT_NUM)) begin
            if (m_mode == MODE_HEADER) begin
                if (int'(b) >= int'(pkts_per_frame) && b != PKT_NUM_NONE) begin
                    bump_discards();
                    m_exp_pkt = '0;
                    m_mode    = MODE_SKIP;
                    if (m_disc > lim_sync) begin
                        push_request(EVT_SYNC);
                    end
                end else if (int'(b) == int'(m_exp_pkt)) begin
                    m_mode = MODE_PIXELS;
                end else begin
                    m_mode = MODE_SKIP;
                end
            end
        end else if (m_mode == MODE_PIXELS && pos >= int'(POS_PIX_FIRST) &&
                     pos < int'(POS_PIX_FIRST + 2 * PIXELS_PER_PACKET_DEF)) begin
            off = pos - int'(POS_PIX_FIRST);
            pix = off / 2;
            if (off % 2 == 0) begin
                m_hold = b;
            end else begin
                last_pix  = (pix == int'(PIXELS_PER_PACKET_DEF) - 1);
                frame_end = last_pix && (int'(m_exp_pkt) + 1 == int'(pkts_per_frame));
                r.code  = EVT_PIXEL;
                r.index = INDEX_W'(int'(m_exp_pkt) * int'(PIXELS_PER_PACKET_DEF) + pix);
                r.value = PIXEL_W'({m_hold, b} >> 2);
                r.done  = frame_end;
                due_events.push_back(r);
                if (last_pix) begin
                    m_mode = MODE_SKIP;
                    if (frame_end) begin
                        m_exp_pkt = '0;
                        m_disc    = '0;
                    end else begin
                        m_exp_pkt = m_exp_pkt + 6'd1;
                    end
                end
            end
        end
    endfunction

    // byte driver
    always @(posedge i_clk) begin : drive_words
        t_rx_word w;
        if (!i_rst_n) begin
            byte_ch.valid        <= 1'b0;
            byte_ch.rx_byte      <= '0;
            byte_ch.packet_start <= 1'b0;
        end else begin
            if (byte_ch.valid && byte_ch.ready) begin
                deframe_word(byte_ch.rx_byte, byte_ch.packet_start);
                words_in++;
            end
            if (!byte_ch.valid || byte_ch.ready) begin
                if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    w = byte_backlog.pop_front();
                    byte_ch.valid        <= 1'b1;
                    byte_ch.rx_byte      <= w.data;
                    byte_ch.packet_start <= w.start;
                end else begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_left <= STALL_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin : watch_results
        t_result e;
        if (!i_rst_n) begin
            pix_ch.ready <= 1'b0;
        end else begin
            if (pix_ch.valid && pix_ch.ready) begin
                if (due_events.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("%0t: unexpected result code %0d index %0d value %0d done %0d",
                                 $time, pix_ch.event_code, pix_ch.pixel_index,
                                 pix_ch.pixel_value, pix_ch.frame_done);
                    end
                    mismatch_count++;
                end else begin
                    e = due_events.pop_front();
                    if (pix_ch.event_code !== e.code || pix_ch.pixel_index !== e.index ||
                        pix_ch.pixel_value !== e.value || pix_ch.frame_done !== e.done) begin
                        if (mismatch_count < 10) begin
                            $display("%0t: mismatch exp code %0d index %0d value %0d done %0d",
                                     $time, e.code, e.index, e.value, e.done);
                            $display("%0t:          got code %0d index %0d value %0d done %0d",
                                     $time, pix_ch.event_code, pix_ch.pixel_index,
                                     pix_ch.pixel_value, pix_ch.frame_done);
                        end
                        mismatch_count++;
                    end
                    case (e.code)
                        EVT_PIXEL: pixel_count++;
                        EVT_SYNC:  sync_count++;
                        EVT_RESET: reset_count++;
                        default: ;
                    endcase
                    if (e.done) begin
                        frame_count++;
                    end
                end
            end
            pix_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic push_word(input logic [BYTE_W-1:0] data, input logic start);
        t_rx_word w;
        w.data  = data;
        w.start = start;
        byte_backlog.push_back(w);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SYNC_LIMIT:  lim_sync       = val;
            CFG_RESET_LIMIT: lim_reset      = val;
            CFG_PPF:         pkts_per_frame = val[PKT_NUM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic start_phase(input int send_pct, input int recv_pct,
                               input int sync_lim, input int reset_lim, input int ppf);
        @(negedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        write_reg(CFG_SYNC_LIMIT, CFG_W'(sync_lim));
        write_reg(CFG_RESET_LIMIT, CFG_W'(reset_lim));
        write_reg(CFG_PPF, CFG_W'(ppf));
        g_exp     = int'(m_exp_pkt);
        g_disc    = int'(m_disc);
        g_aligned = (m_pos == 0);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (byte_backlog.size() != 0 || byte_ch.valid || due_events.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly well-formed packets aimed at the awaited number, plus broken ones
    task automatic plan_traffic(input int n_words);
        int pushed;
        int pick;
        int len;
        int num;
        logic [BYTE_W-1:0] hdr;
        pushed = 0;
        while (pushed < n_words) begin
            pick = (pushed == 0) ? 0 : $urandom_range(99);
            hdr  = BYTE_W'($urandom_range(255));
            if (pick < 55) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(2, PACKET_BYTES_DEF - 1)
                                               : PACKET_BYTES_DEF;
                if (len > n_words - pushed) begin
                    len = (n_words - pushed < 2) ? 2 : n_words - pushed;
                end
                if (hdr[3:0] == DISCARD_NIBBLE) begin
                    hdr[0] = 1'b0;
                end
                push_word(hdr, (g_aligned && $urandom_range(3) == 0) ? 1'b0 : 1'b1);
                push_word(BYTE_W'(g_exp), 1'b0);
                for (int i = 2; i < len; i++) begin
                    push_word(BYTE_W'($urandom_range(255)), 1'b0);
                end
                if (len == PACKET_BYTES_DEF) begin
                    if (g_exp + 1 == int'(pkts_per_frame) || g_exp >= int'(pkts_per_frame)) begin
                        g_exp  = 0;
                        g_disc = 0;
                    end else begin
                        g_exp++;
                    end
                end
                g_aligned = (len == PACKET_BYTES_DEF);
            end else if (pick < 70) begin
                len = $urandom_range(1, 3);
                hdr[3:0] = DISCARD_NIBBLE;
                push_word(hdr, 1'b1);
                for (int i = 1; i < len; i++) begin
                    push_word(BYTE_W'($urandom_range(255)), 1'b0);
                end
                if (g_disc < 65535) begin
                    g_disc++;
                end
                if (g_disc > int'(lim_reset)) begin
                    g_exp  = 0;
                    g_disc = 0;
                end
                g_aligned = 1'b0;
            end else if (pick < 90) begin
                len = $urandom_range(2, 12);
                if (hdr[3:0] == DISCARD_NIBBLE) begin
                    hdr[1] = 1'b0;
                end
                if (pick < 82) begin
                    num = $urandom_range(int'(pkts_per_frame), 254);
                    if (g_disc < 65535) begin
                        g_disc++;
                    end
                    g_exp = 0;
                end else begin
                    num = $urandom_range(1) ? int'(PKT_NUM_NONE)
                                            : $urandom_range(0, int'(pkts_per_frame) - 1);
                end
                push_word(hdr, 1'b1);
                push_word(BYTE_W'(num), 1'b0);
                for (int i = 2; i < len; i++) begin
                    push_word(BYTE_W'($urandom_range(255)), 1'b0);
                end
                g_aligned = 1'b0;
            end else begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++) begin
                    push_word(BYTE_W'($urandom_range(255)), ($urandom_range(3) == 0));
                end
                g_aligned = 1'b0;
            end
            pushed += len;
        end
    endtask

    initial begin
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = CFG_SYNC_LIMIT;
        i_cfg_wdata          = '0;
        byte_ch.valid        = 1'b0;
        byte_ch.rx_byte      = '0;
        byte_ch.packet_start = 1'b0;
        pix_ch.ready         = 1'b0;
        hold_go              = 1'b0;
        hold_left            = 0;
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        words_in             = 0;
        mismatch_count       = 0;
        pixel_count          = 0;
        frame_count          = 0;
        sync_count           = 0;
        reset_count          = 0;
        m_pos                = '0;
        m_exp_pkt            = '0;
        m_disc               = '0;
        m_mode               = MODE_HEADER;
        m_hold               = '0;
        lim_sync             = SYNC_LIMIT_RST;
        lim_reset            = RESET_LIMIT_RST;
        pkts_per_frame       = PPF_RST;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: discard headers up to a reset request, out-of-range and
        // skipped numbers, a few pixels at the value extremes, then an abort
        start_phase(0, 0, 0, 2, 1);
        push_word(8'h0F, 1'b1);
        push_word(8'hFF, 1'b1);
        push_word(8'hAF, 1'b1);
        push_word(8'h00, 1'b1);
        push_word(8'h01, 1'b0);
        push_word(8'h10, 1'b1);
        push_word(PKT_NUM_NONE, 1'b0);
        push_word(8'h00, 1'b1);
        push_word(8'h3F, 1'b0);
        push_word(8'h00, 1'b1);
        push_word(8'h00, 1'b0);
        push_word(8'h12, 1'b0);
        push_word(8'h34, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'hA5, 1'b0);
        push_word(8'h5A, 1'b0);
        push_word(8'h0F, 1'b1);
        push_word(8'h00, 1'b0);
        wait_drained();

        start_phase(0, 0, 3, 5, 1);
        plan_traffic(300);
        wait_drained();

        start_phase(70, 0, 65535, 65535, 2);
        plan_traffic(250);
        wait_drained();

        start_phase(0, 70, 1, 0, 63);
        plan_traffic(300);
        wait_drained();

        // receiver holds off while bytes keep coming, then a full drain mid-phase
        start_phase(21, 21, 10, 20, 3);
        @(posedge i_clk);
        hold_go <= 1'b1;
        @(posedge i_clk);
        hold_go <= 1'b0;
        plan_traffic(200);
        wait_drained();
        plan_traffic(200);
        wait_drained();

        $display("run covered %0d bytes in; %0d pixels, %0d frame ends checked",
                 words_in, pixel_count, frame_count);
        $display("run covered %0d sync and %0d camera reset requests, %0d mismatches",
                 sync_count, reset_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout waiting for results");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
